>>> rtl/core/lsum_pkg.sv
// lsum_pkg: shared types and constants of the lazy sum tree core
// field widths, mode codes, datapath micro-operations, command and status structs
// no dependencies
package lsum_pkg;

  localparam int MODE_W = 2;
  localparam int POS_W  = 11;
  localparam int VAL_W  = 48;

  localparam logic [MODE_W-1:0] MODE_INIT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  localparam logic [1:0] PH_ENTER = 2'd0;
  localparam logic [1:0] PH_LEFT  = 2'd1;
  localparam logic [1:0] PH_RIGHT = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_START,
    OP_CLEAR,
    OP_LEAF,
    OP_POP,
    OP_COVER_RD,
    OP_COVER_WR,
    OP_PD_RD,
    OP_PD_W1,
    OP_PD_W2,
    OP_PD_W3,
    OP_PUSH_L,
    OP_PUSH_R,
    OP_RF_RD,
    OP_RF_SUM,
    OP_RF_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   clr_sum;
    logic   sr_step;
    logic   sr_done;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              empty;
    logic [1:0]        ph;
    logic              leaf;
    logic              disjoint;
    logic              covered;
    logic              clear_done;
    logic              out_busy;
  } dp_sts_t;

endpackage

>>> rtl/core/lsum_ifs.sv
// lsum_in_if, lsum_out_if: valid/ready channels of the lazy sum tree core
// depends on lsum_pkg for the field widths
interface lsum_in_if import lsum_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [POS_W-1:0]        range_low;
  logic [POS_W-1:0]        range_high;
  logic signed [VAL_W-1:0] operand_value;

  modport source (output valid, mode, range_low, range_high, operand_value, input ready);
  modport sink (input valid, mode, range_low, range_high, operand_value, output ready);
endinterface

interface lsum_out_if import lsum_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] found_index;
  logic             overflow;

  modport source (output valid, found_index, overflow, input ready);
  modport sink (input valid, found_index, overflow, output ready);
endinterface

>>> rtl/core/lsum_dp.sv
// lsum_dp: datapath of the lazy sum tree core
// node sum and pending add memories, traversal stack, adders, size register, result register
// depends on lsum_pkg
module lsum_dp import lsum_pkg::*; #(
  parameter int LEAVES    = 1024,
  parameter int SUM_WIDTH = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_sts_t                 sts,
  input  logic                    cfg_we,
  input  logic [POS_W-1:0]        cfg_wdata,
  input  logic [MODE_W-1:0]       in_mode,
  input  logic [POS_W-1:0]        in_range_low,
  input  logic [POS_W-1:0]        in_range_high,
  input  logic signed [VAL_W-1:0] in_operand_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [POS_W-1:0]        out_found_index,
  output logic                    out_overflow
);

  localparam int NODES = 4 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int IW    = $clog2(LEAVES + 1);
  localparam int PW    = (IW > POS_W) ? IW : POS_W;
  localparam int DEPTH = $clog2(LEAVES) + 1;
  localparam int SPW   = $clog2(DEPTH + 1);
  localparam int TW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = SUM_WIDTH;

  typedef struct packed {
    logic [AW-1:0] a;
    logic [PW-1:0] lo;
    logic [PW-1:0] hi;
    logic [1:0]    ph;
  } frame_t;

  logic [SW-1:0] sum_mem  [NODES];
  logic [SW-1:0] pend_mem [NODES];
  logic [SW-1:0] sum_qa, sum_qb, pend_qa, pend_qb;

  logic          sum_we, pend_we, sum_rea, sum_reb, pend_rea, pend_reb;
  logic [AW-1:0] sum_wa, pend_wa, sum_raa, sum_rab, pend_raa, pend_rab;
  logic [SW-1:0] sum_wd, pend_wd;

  logic [POS_W-1:0]  cfg_size_r;
  logic [MODE_W-1:0] mode_r;
  logic [PW-1:0]     wlo_r, whi_r;
  logic [SW-1:0]     want_r, ls_r, s1_r;
  logic              o1_r, ovf_r;
  frame_t            stk_r [DEPTH];
  logic [SPW-1:0]    sp_r;
  logic [AW-1:0]     clr_r;
  logic              out_valid_r, out_ovf_r;
  logic [POS_W-1:0]  out_idx_r;

  logic [IW-1:0]        eff;
  logic [TW-1:0]        tidx, pidx;
  frame_t               top;
  logic [PW-1:0]        mid;
  logic [AW-1:0]        a2, a2p1;
  logic signed [63:0]   v64;
  logic [SW-1:0]        val;
  logic [SW-1:0]        pd_l, pd_p, pd_r, cov_s, cov_p, rf1, rf2, sr_rem;
  logic                 cov_o, rf1_o, rf2_o, sr_lt, at_root;

  // effective size: zero counts as one, clipped at the leaf count
  always_comb begin
    if (cfg_size_r == '0) begin
      eff = IW'(1);
    end else if (int'(cfg_size_r) > LEAVES) begin
      eff = IW'(LEAVES);
    end else begin
      eff = IW'(cfg_size_r);
    end
  end

  assign tidx    = TW'(sp_r - SPW'(1));
  assign pidx    = TW'(sp_r);
  assign top     = stk_r[tidx];
  assign mid     = PW'(({1'b0, top.lo} + {1'b0, top.hi}) >> 1);
  assign a2      = {top.a[AW-2:0], 1'b0};
  assign a2p1    = {top.a[AW-2:0], 1'b1};
  assign at_root = (top.a == AW'(1));
  assign v64     = 64'(in_operand_value);
  assign val     = SW'(v64);

  assign pd_l   = sum_qa + pend_qa;
  assign pd_p   = pend_qb + pend_qa;
  assign pd_r   = sum_qb + pend_qa;
  assign cov_s  = sum_qa + want_r;
  assign cov_p  = pend_qa + want_r;
  assign rf1    = sum_qa + sum_qb;
  assign rf2    = s1_r + pend_qa;
  assign cov_o  = (sum_qa[SW-1] == want_r[SW-1]) && (cov_s[SW-1] != sum_qa[SW-1]);
  assign rf1_o  = (sum_qa[SW-1] == sum_qb[SW-1]) && (rf1[SW-1] != sum_qa[SW-1]);
  assign rf2_o  = (s1_r[SW-1] == pend_qa[SW-1]) && (rf2[SW-1] != s1_r[SW-1]);
  assign sr_lt  = $signed(ls_r) < $signed(want_r);
  assign sr_rem = want_r - ls_r;

  always_comb begin
    sum_we   = 1'b0;
    pend_we  = 1'b0;
    sum_rea  = 1'b0;
    sum_reb  = 1'b0;
    pend_rea = 1'b0;
    pend_reb = 1'b0;
    sum_wa   = top.a;
    pend_wa  = top.a;
    sum_raa  = top.a;
    sum_rab  = a2p1;
    pend_raa = top.a;
    pend_rab = a2;
    sum_wd   = '0;
    pend_wd  = '0;
    case (cmd.op)
      OP_CLEAR: begin
        sum_we  = cmd.clr_sum;
        pend_we = 1'b1;
        sum_wa  = clr_r;
        pend_wa = clr_r;
      end
      OP_LEAF: begin
        sum_we = 1'b1;
        sum_wd = SW'(top.lo - PW'(1));
      end
      OP_COVER_RD: begin
        sum_rea  = 1'b1;
        pend_rea = 1'b1;
      end
      OP_COVER_WR: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        sum_wd  = cov_s;
        pend_wd = cov_p;
      end
      OP_PD_RD: begin
        sum_rea  = 1'b1;
        sum_reb  = 1'b1;
        pend_rea = 1'b1;
        pend_reb = 1'b1;
        sum_raa  = a2;
      end
      OP_PD_W1: begin
        // left child takes the pending add, right child pending read in flight
        pend_reb = 1'b1;
        pend_rab = a2p1;
        sum_we   = 1'b1;
        pend_we  = 1'b1;
        sum_wa   = a2;
        pend_wa  = a2;
        sum_wd   = pd_l;
        pend_wd  = pd_p;
      end
      OP_PD_W2: begin
        sum_we  = 1'b1;
        pend_we = 1'b1;
        sum_wa  = a2p1;
        pend_wa = a2p1;
        sum_wd  = pd_r;
        pend_wd = pd_p;
      end
      OP_PD_W3: begin
        pend_we = 1'b1;
      end
      OP_RF_RD: begin
        sum_rea  = 1'b1;
        sum_reb  = 1'b1;
        pend_rea = 1'b1;
        sum_raa  = a2;
      end
      OP_RF_WR: begin
        sum_we = 1'b1;
        sum_wd = rf2;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    if (sum_rea) sum_qa <= sum_mem[sum_raa];
    if (sum_reb) sum_qb <= sum_mem[sum_rab];
  end

  always_ff @(posedge clk) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_rea) pend_qa <= pend_mem[pend_raa];
    if (pend_reb) pend_qb <= pend_mem[pend_rab];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r  <= POS_W'(1024);
      sp_r        <= '0;
      clr_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) cfg_size_r <= cfg_wdata;
      if (cmd.sr_done) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        OP_START: begin
          sp_r  <= SPW'(1);
          clr_r <= '0;
          if (in_mode == MODE_INIT) ovf_r <= 1'b0;
        end
        OP_CLEAR: clr_r <= clr_r + AW'(1);
        OP_LEAF, OP_POP: sp_r <= sp_r - SPW'(1);
        OP_COVER_WR: begin
          sp_r <= sp_r - SPW'(1);
          if (at_root && cov_o) ovf_r <= 1'b1;
        end
        OP_RF_WR: begin
          sp_r <= sp_r - SPW'(1);
          if (at_root && (o1_r || rf2_o)) ovf_r <= 1'b1;
        end
        OP_PUSH_L, OP_PUSH_R: sp_r <= sp_r + SPW'(1);
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.sr_done) begin
      out_idx_r <= POS_W'(top.lo);
      out_ovf_r <= ovf_r;
    end
    if (cmd.sr_step) begin
      if (sr_lt) begin
        want_r           <= sr_rem;
        stk_r[tidx].a  <= a2p1;
        stk_r[tidx].lo <= mid + PW'(1);
      end else begin
        stk_r[tidx].a  <= a2;
        stk_r[tidx].hi <= mid;
      end
    end
    case (cmd.op)
      OP_START: begin
        mode_r   <= in_mode;
        wlo_r    <= PW'(in_range_low);
        whi_r    <= PW'(in_range_high);
        want_r   <= val;
        stk_r[0] <= '{a: AW'(1), lo: PW'(1), hi: PW'(eff), ph: PH_ENTER};
      end
      OP_PD_W1: ls_r <= pd_l;
      OP_RF_SUM: begin
        s1_r <= rf1;
        o1_r <= rf1_o;
      end
      OP_PUSH_L: begin
        stk_r[tidx].ph <= PH_LEFT;
        stk_r[pidx]    <= '{a: a2, lo: top.lo, hi: mid, ph: PH_ENTER};
      end
      OP_PUSH_R: begin
        stk_r[tidx].ph <= PH_RIGHT;
        stk_r[pidx]    <= '{a: a2p1, lo: mid + PW'(1), hi: top.hi, ph: PH_ENTER};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.mode       = mode_r;
    sts.empty      = (sp_r == '0);
    sts.ph         = top.ph;
    sts.leaf       = (top.lo == top.hi);
    sts.disjoint   = (top.lo > whi_r) || (top.hi < wlo_r);
    sts.covered    = (top.lo >= wlo_r) && (top.hi <= whi_r);
    sts.clear_done = (clr_r == AW'(NODES - 1));
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_found_index = out_idx_r;
  assign out_overflow    = out_ovf_r;

endmodule

>>> rtl/core/lsum_ctrl.sv
// lsum_ctrl: sequencer of the lazy sum tree core
// walks the tree by issuing micro-operations to lsum_dp; depends on lsum_pkg
module lsum_ctrl import lsum_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [MODE_W-1:0] in_mode,
  output logic              in_ready,
  input  dp_sts_t           sts,
  output dp_cmd_t           cmd
);

  typedef enum logic [15:0] {
    S_CLR     = 16'h0001,
    S_IDLE    = 16'h0002,
    S_CLRP    = 16'h0004,
    S_WALK    = 16'h0008,
    S_COV_RD  = 16'h0010,
    S_COV_WR  = 16'h0020,
    S_PD_RD   = 16'h0040,
    S_PD_W1   = 16'h0080,
    S_PD_W2   = 16'h0100,
    S_PD_W3   = 16'h0200,
    S_PUSH_L  = 16'h0400,
    S_RF_RD   = 16'h0800,
    S_RF_SUM  = 16'h1000,
    S_RF_WR   = 16'h2000,
    S_SR_CHK  = 16'h4000,
    S_SR_STEP = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   sr_out_r, sr_out_nxt;

  assign in_ready = (state_r == S_IDLE) && !sr_out_r;

  always_comb begin
    state_nxt   = state_r;
    sr_out_nxt  = sr_out_r;
    cmd.op      = OP_NONE;
    cmd.clr_sum = 1'b0;
    cmd.sr_step = 1'b0;
    cmd.sr_done = 1'b0;
    unique case (state_r)
      S_CLR: begin
        cmd.op      = OP_CLEAR;
        cmd.clr_sum = 1'b1;
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (sr_out_r) begin
          // search result waits for the output register to free up
          if (!sts.out_busy) begin
            cmd.sr_done = 1'b1;
            sr_out_nxt  = 1'b0;
          end
        end else if (in_valid) begin
          cmd.op = OP_START;
          case (in_mode)
            MODE_INIT:   state_nxt = S_CLRP;
            MODE_ADD:    state_nxt = S_WALK;
            MODE_SEARCH: state_nxt = S_SR_CHK;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLRP: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_done) state_nxt = S_WALK;
      end
      S_WALK: begin
        if (sts.empty) begin
          state_nxt = S_IDLE;
        end else if (sts.ph == PH_ENTER) begin
          if (sts.mode == MODE_INIT) begin
            cmd.op = sts.leaf ? OP_LEAF : OP_PUSH_L;
          end else if (sts.disjoint) begin
            cmd.op = OP_POP;
          end else if (sts.covered) begin
            state_nxt = S_COV_RD;
          end else begin
            state_nxt = S_PD_RD;
          end
        end else if (sts.ph == PH_LEFT) begin
          cmd.op = OP_PUSH_R;
        end else begin
          state_nxt = S_RF_RD;
        end
      end
      S_COV_RD: begin
        cmd.op    = OP_COVER_RD;
        state_nxt = S_COV_WR;
      end
      S_COV_WR: begin
        cmd.op    = OP_COVER_WR;
        state_nxt = S_WALK;
      end
      S_PD_RD: begin
        cmd.op    = OP_PD_RD;
        state_nxt = S_PD_W1;
      end
      S_PD_W1: begin
        cmd.op    = OP_PD_W1;
        state_nxt = S_PD_W2;
      end
      S_PD_W2: begin
        cmd.op    = OP_PD_W2;
        state_nxt = S_PD_W3;
      end
      S_PD_W3: begin
        cmd.op    = OP_PD_W3;
        state_nxt = (sts.mode == MODE_SEARCH) ? S_SR_STEP : S_PUSH_L;
      end
      S_PUSH_L: begin
        cmd.op    = OP_PUSH_L;
        state_nxt = S_WALK;
      end
      S_RF_RD: begin
        cmd.op    = OP_RF_RD;
        state_nxt = S_RF_SUM;
      end
      S_RF_SUM: begin
        cmd.op    = OP_RF_SUM;
        state_nxt = S_RF_WR;
      end
      S_RF_WR: begin
        cmd.op    = OP_RF_WR;
        state_nxt = S_WALK;
      end
      S_SR_CHK: begin
        if (sts.leaf) begin
          state_nxt = S_IDLE;
          if (!sts.out_busy) begin
            cmd.sr_done = 1'b1;
          end else begin
            sr_out_nxt = 1'b1;
          end
        end else begin
          state_nxt = S_PD_RD;
        end
      end
      S_SR_STEP: begin
        cmd.sr_step = 1'b1;
        state_nxt   = S_SR_CHK;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      sr_out_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sr_out_r <= sr_out_nxt;
    end
  end

endmodule

>>> rtl/core/lazy_sum_tree_add_and_prefix_search_core.sv
// lazy sum tree with range add and prefix search, S = effective size (1..LEAVES)
// search: each tree level does a push-down read-modify-write on the single write port
// of each node memory
// range add: pops disjoint nodes, updates covered ones, splits the rest
// init: clears all pending adds, then writes each leaf and sums each inner node
// reset: synchronous rst_n, then a clearing pass with in_ch.ready low
module lazy_sum_tree_add_and_prefix_search_core import lsum_pkg::*; #(
  parameter int LEAVES    = 1024,
  parameter int SUM_WIDTH = 48
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [POS_W-1:0] cfg_wdata,
  lsum_in_if.sink          in_ch,
  lsum_out_if.source       out_ch
);

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: owns the input handshake and the walk order over the tree
  lsum_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: node memories, stack of open nodes, output word register
  lsum_dp #(
    .LEAVES    (LEAVES),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_ch.mode),
    .in_range_low     (in_ch.range_low),
    .in_range_high    (in_ch.range_high),
    .in_operand_value (in_ch.operand_value),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_found_index  (out_ch.found_index),
    .out_overflow     (out_ch.overflow)
  );

endmodule
